/* src/arx_pkg.sv */
package arx_pkg;

  localparam int DOUBLE_ROUNDS = 12;
  localparam int NSTAGES = 4 * DOUBLE_ROUNDS;

  localparam logic [31:0] SIGMA_0 = 32'h6F6C6C76;
  localparam logic [31:0] SIGMA_1 = 32'h6D2D6B65;
  localparam logic [31:0] SIGMA_2 = 32'h79323178;
  localparam logic [31:0] SIGMA_3 = 32'h21212121;

  localparam logic [31:0] KEY_0 = 32'h564C4C4F;
  localparam logic [31:0] KEY_1 = 32'h59454B4D;
  localparam logic [31:0] KEY_2 = 32'h21583132;
  localparam logic [31:0] KEY_3 = 32'h21212121;
  localparam logic [31:0] KEY_4 = 32'h2D7BF9A3;
  localparam logic [31:0] KEY_5 = 32'h9FE488C1;
  localparam logic [31:0] KEY_6 = 32'h42DA016E;
  localparam logic [31:0] KEY_7 = 32'h8C7155B3;

  localparam logic [31:0] NONCE_0 = 32'h78563412;
  localparam logic [31:0] NONCE_1 = 32'hF0DEBC9A;
  localparam logic [31:0] NONCE_2 = 32'h44332211;

  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    state_t      words;
    logic [31:0] ctr;
  } blk_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  function automatic state_t init_state(input logic [31:0] ctr);
    state_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    s[4]  = KEY_0;
    s[5]  = KEY_1;
    s[6]  = KEY_2;
    s[7]  = KEY_3;
    s[8]  = KEY_4;
    s[9]  = KEY_5;
    s[10] = KEY_6;
    s[11] = KEY_7;
    s[12] = ctr;
    s[13] = NONCE_0;
    s[14] = NONCE_1;
    s[15] = NONCE_2;
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one half of a quarter round: two add/xor/rotate steps
  function automatic quad_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [31:0] d,
                                    input int unsigned r1, input int unsigned r2);
    quad_t q;
    q.a = a + b;
    q.d = rotl32(d ^ q.a, r1);
    q.c = c + q.d;
    q.b = rotl32(b ^ q.c, r2);
    return q;
  endfunction

endpackage

/* src/arx_ifs.sv */
interface arx_ctr_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_counter;

  modport source (output valid, output block_counter, input ready);
  modport sink (input valid, input block_counter, output ready);
endinterface

interface arx_ks_if;
  logic        valid;
  logic        ready;
  logic [63:0] stream_bytes_0_7;
  logic [63:0] stream_bytes_8_15;
  logic [63:0] stream_bytes_16_23;
  logic [63:0] stream_bytes_24_31;
  logic [63:0] stream_bytes_32_39;
  logic [63:0] stream_bytes_40_47;
  logic [63:0] stream_bytes_48_55;
  logic [63:0] stream_bytes_56_63;

  modport source (
    output valid, input ready,
    output stream_bytes_0_7, output stream_bytes_8_15,
    output stream_bytes_16_23, output stream_bytes_24_31,
    output stream_bytes_32_39, output stream_bytes_40_47,
    output stream_bytes_48_55, output stream_bytes_56_63
  );
  modport sink (
    input valid, output ready,
    input stream_bytes_0_7, input stream_bytes_8_15,
    input stream_bytes_16_23, input stream_bytes_24_31,
    input stream_bytes_32_39, input stream_bytes_40_47,
    input stream_bytes_48_55, input stream_bytes_56_63
  );
endinterface

/* src/arx_round_pipe.sv */
module arx_round_pipe (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  arx_pkg::blk_t in_blk,
  output logic         tail_valid,
  output arx_pkg::blk_t tail_blk
);

  logic [arx_pkg::NSTAGES-1:0] vld;
  arx_pkg::blk_t               st [arx_pkg::NSTAGES];

  for (genvar g = 0; g < arx_pkg::NSTAGES; g++) begin : g_stage
    // column pass then diagonal pass, each split in two halves
    localparam int DIAG = ((g % 4) >= 2) ? 1 : 0;
    localparam int SECOND = g % 2;
    localparam int unsigned R1 = (SECOND != 0) ? 5 : 13;
    localparam int unsigned R2 = (SECOND != 0) ? 11 : 9;

    arx_pkg::blk_t src;
    arx_pkg::blk_t nxt;
    logic          src_v;

    if (g == 0) begin : g_first
      assign src   = in_blk;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = st[g-1];
      assign src_v = vld[g-1];
    end

    always_comb begin
      logic [3:0]     ia;
      logic [3:0]     ib;
      logic [3:0]     ic;
      logic [3:0]     id;
      arx_pkg::quad_t q;
      nxt = src;
      for (int l = 0; l < 4; l++) begin
        ia = 4'(l);
        ib = 4'(4 + ((l + DIAG) % 4));
        ic = 4'(8 + ((l + 2 * DIAG) % 4));
        id = 4'(12 + ((l + 3 * DIAG) % 4));
        q = arx_pkg::qr_half(src.words[ia], src.words[ib], src.words[ic],
                             src.words[id], R1, R2);
        nxt.words[ia] = q.a;
        nxt.words[ib] = q.b;
        nxt.words[ic] = q.c;
        nxt.words[id] = q.d;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g] <= nxt;
      end
    end
  end

  assign tail_valid = vld[arx_pkg::NSTAGES-1];
  assign tail_blk   = st[arx_pkg::NSTAGES-1];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[0] == $past(in_valid))
    else $error("input word not taken into first stage");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[arx_pkg::NSTAGES-1] == $past(vld[arx_pkg::NSTAGES-2]))
    else $error("valid bit lost or repeated at pipe tail");

  a_ctr_follow: assert property (@(posedge clk) disable iff (rst)
    en && vld[0] |=> st[1].ctr == $past(st[0].ctr))
    else $error("counter not carried with its word");

endmodule

/* src/arx_out_stage.sv */
module arx_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           tail_valid,
  input  arx_pkg::blk_t  tail_blk,
  output logic           advance,
  arx_ks_if.source       ks
);

  logic            valid;
  arx_pkg::state_t res;
  arx_pkg::state_t init;

  assign advance = !valid || ks.ready;
  assign init    = arx_pkg::init_state(tail_blk.ctr);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= tail_valid;
    end
  end

  // feed-forward add of the initial state
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 16; i++) begin
        res[i] <= tail_blk.words[i] + init[i];
      end
    end
  end

  assign ks.valid              = valid;
  assign ks.stream_bytes_0_7   = {res[1], res[0]};
  assign ks.stream_bytes_8_15  = {res[3], res[2]};
  assign ks.stream_bytes_16_23 = {res[5], res[4]};
  assign ks.stream_bytes_24_31 = {res[7], res[6]};
  assign ks.stream_bytes_32_39 = {res[9], res[8]};
  assign ks.stream_bytes_40_47 = {res[11], res[10]};
  assign ks.stream_bytes_48_55 = {res[13], res[12]};
  assign ks.stream_bytes_56_63 = {res[15], res[14]};

endmodule

/* src/arx_stream_cipher_block_unit.sv */
// path: round pipe stages, then the output register, from accepted counter word to keystream word
// throughput: one block per cycle while no output word waits, one pipe stage per half quarter-round pass
// the whole pipe advances together; it holds only while an output word waits
// reset: synchronous, active high, clears valid bits only; no data reset
module arx_stream_cipher_block_unit (
  input  logic     clk,
  input  logic     rst,
  arx_ctr_if.sink  counter,
  arx_ks_if.source keystream
);

  logic          advance;
  logic          tail_valid;
  arx_pkg::blk_t in_blk;
  arx_pkg::blk_t tail_blk;

  assign in_blk.words = arx_pkg::init_state(counter.block_counter);
  assign in_blk.ctr   = counter.block_counter;
  assign counter.ready = advance;

  arx_round_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .in_valid   (counter.valid),
    .in_blk     (in_blk),
    .tail_valid (tail_valid),
    .tail_blk   (tail_blk)
  );

  arx_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .tail_valid (tail_valid),
    .tail_blk   (tail_blk),
    .advance    (advance),
    .ks         (keystream)
  );

endmodule

/* verif/tb_arx_stream_cipher_block_unit.sv */
typedef logic [7:0][63:0] ks_block_t;

class ks_tracker;
  ks_block_t   expected_blocks[$];
  int          mismatches;
  logic [31:0] sigma_tab [4];
  logic [7:0]  key_tab [32];
  logic [7:0]  nonce_tab [12];

  function new();
    mismatches = 0;
    sigma_tab = '{32'h6F6C6C76, 32'h6D2D6B65, 32'h79323178, 32'h21212121};
    key_tab = '{8'h4F, 8'h4C, 8'h4C, 8'h56, 8'h4D, 8'h4B, 8'h45, 8'h59,
                8'h32, 8'h31, 8'h58, 8'h21, 8'h21, 8'h21, 8'h21, 8'h21,
                8'hA3, 8'hF9, 8'h7B, 8'h2D, 8'hC1, 8'h88, 8'hE4, 8'h9F,
                8'h6E, 8'h01, 8'hDA, 8'h42, 8'hB3, 8'h55, 8'h71, 8'h8C};
    nonce_tab = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0,
                  8'h11, 8'h22, 8'h33, 8'h44};
  endfunction

  function logic [31:0] rol(logic [31:0] v, int n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function void mix(inout logic [31:0] a, inout logic [31:0] b,
                    inout logic [31:0] c, inout logic [31:0] d);
    a = a + b; d = rol(d ^ a, 13);
    c = c + d; b = rol(b ^ c, 9);
    a = a + b; d = rol(d ^ a, 5);
    c = c + d; b = rol(b ^ c, 11);
  endfunction

  function ks_block_t predict_block(logic [31:0] ctr);
    logic [31:0] start [16];
    logic [31:0] w [16];
    ks_block_t   blk;
    for (int i = 0; i < 4; i++) start[i] = sigma_tab[i];
    for (int i = 0; i < 8; i++)
      start[4 + i] = {key_tab[4*i+3], key_tab[4*i+2], key_tab[4*i+1], key_tab[4*i]};
    start[12] = ctr;
    for (int i = 0; i < 3; i++)
      start[13 + i] = {nonce_tab[4*i+3], nonce_tab[4*i+2], nonce_tab[4*i+1], nonce_tab[4*i]};
    w = start;
    for (int r = 0; r < arx_pkg::DOUBLE_ROUNDS; r++) begin
      mix(w[0], w[4], w[8], w[12]);
      mix(w[1], w[5], w[9], w[13]);
      mix(w[2], w[6], w[10], w[14]);
      mix(w[3], w[7], w[11], w[15]);
      mix(w[0], w[5], w[10], w[15]);
      mix(w[1], w[6], w[11], w[12]);
      mix(w[2], w[7], w[8], w[13]);
      mix(w[3], w[4], w[9], w[14]);
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + start[i];
    for (int j = 0; j < 8; j++) blk[j] = {w[2*j+1], w[2*j]};
    return blk;
  endfunction

  function void note_counter(logic [31:0] ctr);
    expected_blocks.insert(expected_blocks.size(), predict_block(ctr));
  endfunction

  function void check_block(ks_block_t got);
    ks_block_t want;
    if (expected_blocks.size() == 0) begin
      $display("%0t: unexpected keystream word, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_blocks.pop_front();
    for (int j = 0; j < 8; j++) begin
      if (got[j] !== want[j]) begin
        $display("%0t: keystream field %0d expected %h actual %h", $time, j, want[j], got[j]);
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return expected_blocks.size();
  endfunction
endclass

module tb_arx_stream_cipher_block_unit;
  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   rx_hold_cycles;

  ks_tracker sb = new();

  arx_ctr_if ctr_ch();
  arx_ks_if  ks_ch();

  arx_stream_cipher_block_unit DUT (
    .clk(clk),
    .rst(rst),
    .counter(ctr_ch),
    .keystream(ks_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off
  initial begin
    ks_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        ks_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        ks_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (ctr_ch.valid && ctr_ch.ready) sb.note_counter(ctr_ch.block_counter);
        if (ks_ch.valid && ks_ch.ready)
          sb.check_block({ks_ch.stream_bytes_56_63, ks_ch.stream_bytes_48_55,
                          ks_ch.stream_bytes_40_47, ks_ch.stream_bytes_32_39,
                          ks_ch.stream_bytes_24_31, ks_ch.stream_bytes_16_23,
                          ks_ch.stream_bytes_8_15, ks_ch.stream_bytes_0_7});
      end
    end
  end

  task automatic send_counter(input logic [31:0] c);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      ctr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ctr_ch.valid         <= 1'b1;
    ctr_ch.block_counter <= c;
    do @(posedge clk); while (!ctr_ch.ready);
  endtask

  // mostly consecutive counter runs, some near the wrap point, plus lone values
  task automatic send_random_counters(input int count);
    int          left;
    int          run;
    logic [31:0] c;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) < 7) begin
        c = ($urandom_range(3) == 0) ? 32'hFFFFFFFF - $urandom_range(8) : $urandom();
        run = $urandom_range(16, 1);
        repeat (run) begin
          send_counter(c);
          c = c + 1;
          left--;
        end
      end else begin
        send_counter($urandom());
        left--;
      end
    end
  endtask

  task automatic wait_for_keystream_drain();
    @(negedge clk);
    ctr_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] corner [18];
    corner = '{32'h00000000, 32'h00000001, 32'h00000002, 32'hFFFFFFFF, 32'h00000000,
               32'hFFFFFFFE, 32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
               32'h0000FFFF, 32'hFFFF0000, 32'h00FF00FF, 32'hFF00FF00, 32'h12345678,
               32'h87654321, 32'h0F0F0F0F, 32'hF0F0F0F0};
    rst                  = 1'b1;
    ctr_ch.valid         = 1'b0;
    ctr_ch.block_counter = '0;
    tx_idle_pct          = 6;
    rx_idle_pct          = 84;
    rx_hold_cycles       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corner[i]) send_counter(corner[i]);
    send_random_counters(260);
    wait_for_keystream_drain();

    tx_idle_pct = 84;
    rx_idle_pct = 6;
    send_random_counters(260);
    wait_for_keystream_drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_counters(130);
    rx_hold_cycles = 150;
    send_random_counters(130);
    wait_for_keystream_drain();

    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
src/arx_pkg.sv
src/arx_ifs.sv
src/arx_round_pipe.sv
src/arx_out_stage.sv
src/arx_stream_cipher_block_unit.sv
verif/tb_arx_stream_cipher_block_unit.sv
